@@ src/khm_pkg.sv @@
// Shared types and constants of the k-way heap merge engine.
package khm_pkg;

  localparam int unsigned Runs      = 16;
  localparam int unsigned RunDepth  = 1024;
  localparam int unsigned RunW      = $clog2(Runs);
  localparam int unsigned DepthW    = $clog2(RunDepth);
  localparam int unsigned LenW      = $clog2(RunDepth + 1);
  localparam int unsigned SlotW     = $clog2(Runs + 1);
  localparam int unsigned AddrW     = RunW + DepthW;
  localparam int unsigned EntryW    = 48;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdLoad  = 2'd0;
  localparam cmd_t CmdStart = 2'd1;
  localparam cmd_t CmdPop   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t StOk    = 2'd0;
  localparam status_t StFull  = 2'd1;
  localparam status_t StEmpty = 2'd2;

  // Memory address of the tail entry of a run with n entries left.
  function automatic logic [AddrW-1:0] tail_addr(logic [RunW-1:0] r, logic [LenW-1:0] n);
    logic [LenW-1:0] m;
    m = n - LenW'(1);
    return {r, m[DepthW-1:0]};
  endfunction

endpackage

@@ src/khm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module khm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/kway_heap_merge_top.sv @@
// Top level of the k-way heap merge engine: run memory, heap slots and sequencer.
//
// Requests arrive on s_axis (command, run, key, site) and each yields exactly one
// response on m_axis. A pop walks down the heap one level at a time; each level
// reads the two child entries from the single-read run memory one after the other
// and compares each with the running minimum in one shared 48-bit comparator,
// skipping the right child when the slot has none. A start scans all Runs run
// lengths (one per cycle) and then sifts down each internal slot. The block takes
// no new request while one is in progress or while a response waits to be taken.
module kway_heap_merge_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [5:2] run_id, [21:6] key, [53:22] site, zero padded
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_key, [47:16] out_site, [49:48] status, zero padded
  output logic [55:0] m_axis_tdata
);
  import khm_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SLoad, SScan, SBuild, SPopRd, SPopWt, SPopOut,
    SSift, SRdL, SCmpL, SRdR, SCmpR, SSwap, SResp
  } state_e;

  state_e             state_q;
  logic [LenW-1:0]    len_q  [Runs];
  logic [RunW-1:0]    srun_q [Runs+1];
  logic [LenW-1:0]    srem_q [Runs+1];
  logic [SlotW-1:0]   size_q, i_q, m_q, bld_q;
  logic [RunW:0]      scan_q;
  logic [EntryW-1:0]  me_q;
  logic               build_q;
  logic [RunW-1:0]    rid_q;
  logic [EntryW-1:0]  ent_q;
  logic [15:0]        ok_q;
  logic [31:0]        os_q;
  status_t            st_q;
  logic               resp_q;

  // Run memory
  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [EntryW-1:0]  rdata;
  logic [RunW-1:0]    rd_run;
  logic [LenW-1:0]    rd_n;
  logic [SlotW-1:0]   lidx, ridx;

  assign lidx = {i_q[SlotW-2:0], 1'b0};
  assign ridx = {i_q[SlotW-2:0], 1'b1};

  always_comb begin
    rd_run = srun_q[1][RunW-1:0];
    rd_n   = srem_q[1];
    case (state_q)
      SSift:   begin rd_run = srun_q[i_q]; rd_n = srem_q[i_q]; end
      SRdL:    begin rd_run = srun_q[lidx]; rd_n = srem_q[lidx]; end
      SCmpL:   begin rd_run = srun_q[ridx]; rd_n = srem_q[ridx]; end
      SRdR:    begin rd_run = srun_q[ridx]; rd_n = srem_q[ridx]; end
      default: ;
    endcase
    raddr = tail_addr(rd_run, rd_n);
  end

  assign we    = (state_q == SLoad) && (len_q[rid_q] < LenW'(RunDepth));
  assign waddr = {rid_q, len_q[rid_q][DepthW-1:0]};

  khm_ram #(.Width(EntryW), .Depth(Runs*RunDepth)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ent_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Handshake
  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = resp_q;
  assign m_axis_tdata  = {6'd0, st_q, os_q, ok_q};

  logic [SlotW-1:0] half;
  assign half = size_q >> 1;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      size_q  <= '0;
      resp_q  <= 1'b0;
      build_q <= 1'b0;
      for (int k = 0; k < Runs; k++) len_q[k] <= '0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            rid_q <= s_axis_tdata[5:2];
            ent_q <= {s_axis_tdata[21:6], s_axis_tdata[53:22]};
            ok_q  <= '0;
            os_q  <= '0;
            st_q  <= StOk;
            unique case (s_axis_tdata[1:0])
              CmdLoad:  state_q <= SLoad;
              CmdStart: begin
                scan_q  <= '0;
                size_q  <= '0;
                state_q <= SScan;
              end
              CmdPop:   state_q <= SPopRd;
              default:  state_q <= SResp;
            endcase
          end
        end
        SLoad: begin
          if (we) len_q[rid_q] <= len_q[rid_q] + LenW'(1);
          else st_q <= StFull;
          state_q <= SResp;
        end
        SScan: begin
          if (scan_q == (RunW+1)'(Runs)) begin
            bld_q   <= half;
            build_q <= 1'b1;
            state_q <= SBuild;
          end else begin
            if (len_q[scan_q[RunW-1:0]] != '0) begin
              srun_q[size_q + SlotW'(1)] <= scan_q[RunW-1:0];
              srem_q[size_q + SlotW'(1)] <= len_q[scan_q[RunW-1:0]];
              size_q <= size_q + SlotW'(1);
            end
            scan_q <= scan_q + (RunW+1)'(1);
          end
        end
        SBuild: begin
          if (bld_q == '0) begin
            build_q <= 1'b0;
            state_q <= SResp;
          end else begin
            i_q     <= bld_q;
            bld_q   <= bld_q - SlotW'(1);
            state_q <= SSift;
          end
        end
        SPopRd: begin
          if (size_q == '0 || srem_q[1] == '0) begin
            st_q    <= StEmpty;
            state_q <= SResp;
          end else begin
            state_q <= SPopWt;
          end
        end
        SPopWt: state_q <= SPopOut;
        SPopOut: begin
          ok_q <= rdata[47:32];
          os_q <= rdata[31:0];
          i_q  <= SlotW'(1);
          // exhausted run: last slot moves to the root, the heap shrinks
          if (srem_q[1] == LenW'(1)) begin
            srun_q[1] <= srun_q[size_q];
            srem_q[1] <= srem_q[size_q];
            size_q <= size_q - SlotW'(1);
          end else begin
            srem_q[1] <= srem_q[1] - LenW'(1);
          end
          state_q <= SSift;
        end
        // Read the current slot's entry as the running minimum
        SSift: begin
          m_q <= i_q;
          if (i_q > half) state_q <= build_q ? SBuild : SResp;
          else state_q <= SRdL;
        end
        SRdL: begin
          me_q    <= rdata;
          state_q <= SCmpL;
        end
        SCmpL: begin
          if (rdata < me_q) begin
            me_q <= rdata;
            m_q  <= lidx;
          end
          state_q <= SRdR;
        end
        SRdR: begin
          state_q <= (ridx <= size_q) ? SCmpR : SSwap;
        end
        SCmpR: begin
          if (rdata < me_q) m_q <= ridx;
          state_q <= SSwap;
        end
        SSwap: begin
          if (m_q == i_q) begin
            state_q <= build_q ? SBuild : SResp;
          end else begin
            srun_q[i_q] <= srun_q[m_q];
            srem_q[i_q] <= srem_q[m_q];
            srun_q[m_q] <= srun_q[i_q];
            srem_q[m_q] <= srem_q[i_q];
            i_q     <= m_q;
            state_q <= SSift;
          end
        end
        SResp: begin
          if (!resp_q) begin
            resp_q <= 1'b1;
          end else if (m_axis_tready) begin
            resp_q  <= 1'b0;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

@@ tb/sv/khm_checker.sv @@
// Checker for the k-way heap merge engine: watches both streams, predicts and compares.
module khm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          pops_ok_o
);
  import khm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] site;
    status_t     status;
  } reply_t;

  // predicted engine state
  logic [47:0]     run_mem [Runs][RunDepth];
  int unsigned     run_len [Runs];
  int unsigned     slot_src [Runs+1];
  int unsigned     slot_left [Runs+1];
  int unsigned     heap_cnt;
  reply_t          replies_due[$];
  int              fails;

  assign fail_count_o = fails;

  function automatic logic [47:0] head_of(int unsigned s);
    if (slot_left[s] == 0) return '0;
    return run_mem[slot_src[s]][slot_left[s]-1];
  endfunction

  function automatic void swap_slot(int unsigned a, int unsigned b);
    int unsigned t;
    t = slot_src[a];  slot_src[a]  = slot_src[b];  slot_src[b]  = t;
    t = slot_left[a]; slot_left[a] = slot_left[b]; slot_left[b] = t;
  endfunction

  function automatic void sift(int unsigned i);
    int unsigned m;
    while (i <= heap_cnt / 2) begin
      m = i;
      if (2*i <= heap_cnt && head_of(2*i) < head_of(m)) m = 2*i;
      if (2*i+1 <= heap_cnt && head_of(2*i+1) < head_of(m)) m = 2*i+1;
      if (m == i) break;
      swap_slot(i, m);
      i = m;
    end
  endfunction

  // one request in, one reply predicted
  function automatic reply_t merge_step(logic [55:0] d);
    reply_t      r;
    cmd_t        c;
    int unsigned rid;
    logic [47:0] e;
    r   = '0;
    c   = d[1:0];
    rid = d[5:2];
    case (c)
      CmdLoad: begin
        if (run_len[rid] >= RunDepth) r.status = StFull;
        else begin
          run_mem[rid][run_len[rid]] = {d[21:6], d[53:22]};
          run_len[rid]++;
        end
      end
      CmdStart: begin
        heap_cnt = 0;
        for (int q = 0; q < Runs; q++) begin
          if (run_len[q] != 0) begin
            heap_cnt++;
            slot_src[heap_cnt]  = q;
            slot_left[heap_cnt] = run_len[q];
          end
        end
        for (int i = heap_cnt / 2; i >= 1; i--) sift(i);
      end
      CmdPop: begin
        if (heap_cnt == 0 || slot_left[1] == 0) r.status = StEmpty;
        else begin
          e = head_of(1);
          r.key  = e[47:32];
          r.site = e[31:0];
          slot_left[1]--;
          if (slot_left[1] == 0) begin
            swap_slot(1, heap_cnt);
            heap_cnt--;
          end
          sift(1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want, got;
    if (!rst_ni) begin
      for (int q = 0; q < Runs; q++) run_len[q] = 0;
      heap_cnt = 0;
      fails = 0;
      pops_ok_o = 0;
      replies_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.key    = m_axis_tdata[15:0];
        got.site   = m_axis_tdata[47:16];
        got.status = m_axis_tdata[49:48];
        if (replies_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected reply %h", m_axis_tdata);
        end else begin
          want = replies_due.pop_front();
          if (want !== got || m_axis_tdata[55:50] !== '0) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected key %h site %h st %0d, got key %h site %h st %0d",
                       want.key, want.site, want.status, got.key, got.site, got.status);
          end else if (got.status == StOk && got.key != 0) pops_ok_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_due.push_back(merge_step(s_axis_tdata));
    end
    pending_o = replies_due.size();
  end

  // leftovers at the end are counted by the top
endmodule

@@ tb/sv/tb_kway_heap_merge_top.sv @@
// Stimulus and verdict for the k-way heap merge engine.
module tb_kway_heap_merge_top;
  import khm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // command code the engine ignores
  localparam cmd_t CmdUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  int          fail_count, pending, pops_ok;
  bit          quiet_phase;
  bit          hold_off;
  int          requests_sent;

  kway_heap_merge_top uut (.*);

  khm_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .pops_ok_o(pops_ok)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // limit
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    hold_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else m_axis_tready <= quiet_phase || ($urandom_range(99) >= 8);
    end
  end

  function automatic logic [55:0] pack_req(cmd_t c, int unsigned rid, logic [15:0] k,
                                           logic [31:0] s);
    return {2'b00, s, k, 4'(rid), c};
  endfunction

  task automatic send(logic [55:0] d);
    while (!quiet_phase && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // load a run with mostly descending entries, random content
  task automatic load_run(int unsigned rid, int unsigned n);
    logic [15:0] k;
    logic [31:0] s;
    k = 16'($urandom_range(65535, 40000));
    s = $urandom;
    for (int i = 0; i < n; i++) begin
      send(pack_req(CmdLoad, rid, k, s));
      if ($urandom_range(3) == 0) s = s - $urandom_range(50);
      else k = k - 16'($urandom_range(3000));
      if ($urandom_range(9) == 0) begin k = 16'($urandom); s = $urandom; end
    end
  endtask

  initial begin
    int unsigned n;
    quiet_phase   = 1'b0;
    requests_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, unused command, extremes, equal keys
    send(pack_req(CmdPop, 0, 16'hffff, '1));
    send(pack_req(CmdUnused, 15, '1, '1));
    send(pack_req(CmdStart, 0, 0, 0));
    send(pack_req(CmdPop, 0, 0, 0));
    send(pack_req(CmdLoad, 0, 16'hffff, 32'hffffffff));
    send(pack_req(CmdLoad, 0, 16'h0000, 32'h00000000));
    send(pack_req(CmdLoad, 15, 16'h5555, 32'haaaaaaaa));
    send(pack_req(CmdLoad, 15, 16'h5555, 32'h55555555));
    send(pack_req(CmdLoad, 7, 16'haaaa, 32'h12345678));
    send(pack_req(CmdStart, 0, 0, 0));
    send(pack_req(CmdLoad, 7, 16'h0001, 32'h1));  // load while merging
    for (int i = 0; i < 7; i++) send(pack_req(CmdPop, 0, 0, 0));
    send(pack_req(CmdStart, 0, 0, 0));             // replay same runs
    for (int i = 0; i < 7; i++) send(pack_req(CmdPop, 0, 0, 0));
    drain();

    // pressure: keep loading a run with the receiver held off
    hold_off = 1'b1;
    fork
      begin repeat (300) @(posedge clk_i); hold_off = 1'b0; end
      load_run(3, 60);
    join
    drain();

    // quiet stretch, then random merge rounds
    quiet_phase = 1'b1;
    for (int round = 0; round < 10; round++) begin
      if (round == 2) quiet_phase = 1'b0;
      n = $urandom_range(5, 1);
      for (int r = 0; r < n; r++) load_run($urandom_range(15), $urandom_range(6, 1));
      send(pack_req(CmdStart, 0, 0, 0));
      for (int p = 0; p < 25; p++) begin
        case ($urandom_range(19))
          0:       send(pack_req(CmdLoad, $urandom_range(15), 16'($urandom), $urandom));
          1:       send(pack_req(CmdUnused, $urandom, 16'($urandom), $urandom));
          default: send(pack_req(CmdPop, $urandom, 16'($urandom), $urandom));
        endcase
      end
      drain();
    end

    // wait out the last reply
    fork
      begin drain(); repeat (200) @(posedge clk_i); end
      begin repeat (200000) @(posedge clk_i); $display("tb: failure"); $finish; end
    join_any
    $display("covered %0d requests, %0d non-zero pops, empty heap, loads mid-merge, replays",
             requests_sent, pops_ok);
    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ files.f @@
src/khm_pkg.sv
src/khm_ram.sv
src/kway_heap_merge_top.sv
tb/sv/khm_checker.sv
tb/sv/tb_kway_heap_merge_top.sv
